>>> design/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge once reset has been released.
`define MKL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising clock edge, reset included.
`define MKL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MKL_ASSERT(lbl, prop, msg)
`define MKL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/mkl_pkg.sv
// Types and constants shared by the MRU key list modules.
package mkl_pkg;

  // Widths fixed by the item, result and config fields.
  localparam int CMD_BITS    = 2;
  localparam int POS_BITS    = 4;
  localparam int CAP_BITS    = 5;

  // Capacity after reset, and the most results one read out gives.
  localparam int CAP_RESET   = 16;
  localparam int MAX_RESULTS = 16;

  // Items held between the front and the back; a power of two.
  localparam int QUEUE_DEPTH = 2;

  // Command codes as they arrive on the cmd field.
  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd3;

  // Operation after classification in the front.
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_CLEAR,
    OP_READ
  } mkl_op_e;

  // Back-end sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } mkl_state_e;

  // Head of the item queue as the back sees it.
  typedef struct packed {
    logic    valid;
    mkl_op_e op;
  } mkl_head_t;

endpackage

>>> design/mkl_front.sv
// Front end: accepts items, classifies the command and queues them for the back.
module mkl_front import mkl_pkg::*; #(
  parameter int KEY_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [CMD_BITS-1:0] cmd_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic                pop_i,
  output logic                full_o,
  output mkl_head_t           head_o,
  output logic [KEY_BITS-1:0] head_key_o
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  mkl_op_e             op_q  [QUEUE_DEPTH];
  logic [KEY_BITS-1:0] key_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  mkl_op_e             op_in;
  logic                do_push;
  logic                do_pop;

  // Classify the incoming command.
  always_comb begin
    case (cmd_i)
      CMD_INSERT: op_in = OP_INSERT;
      CMD_REMOVE: op_in = OP_REMOVE;
      CMD_CLEAR:  op_in = OP_CLEAR;
      CMD_READ:   op_in = OP_READ;
      default:    op_in = OP_READ;
    endcase
  end

  assign full_o  = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (fill_q != '0);

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? PTR_W'(wr_ptr_q + PTR_W'(1)) : wr_ptr_q;
    rd_ptr_d = do_pop  ? PTR_W'(rd_ptr_q + PTR_W'(1)) : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage; no reset needed for the payload.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      op_q[wr_ptr_q]  <= op_in;
      key_q[wr_ptr_q] <= key_i;
    end
  end

  // Present the oldest item to the back.
  assign head_o.valid = (fill_q != '0);
  assign head_o.op    = op_q[rd_ptr_q];
  assign head_key_o   = key_q[rd_ptr_q];

endmodule

>>> design/mkl_back.sv
// Back end: the list cells with per-cell compare, the read-out sequencer and the result register.
module mkl_back import mkl_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CAP_BITS-1:0] cfg_data_i,
  input  mkl_head_t           head_i,
  input  logic [KEY_BITS-1:0] head_key_i,
  output logic                pop_o,
  output logic                idle_o,
  output logic                res_valid_o,
  output logic [KEY_BITS-1:0] res_key_o,
  output logic [POS_BITS-1:0] res_pos_o,
  output logic                res_empty_o,
  output logic                res_last_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAPW  = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  mkl_state_e          state_q, state_d;
  logic [CAP_BITS-1:0] cap_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic [KEY_BITS-1:0] ent_q [DEPTH];
  logic [KEY_BITS-1:0] ent_d [DEPTH];

  logic                res_valid_q;
  logic [KEY_BITS-1:0] res_key_q;
  logic [POS_BITS-1:0] res_pos_q;
  logic                res_empty_q;
  logic                res_last_q;

  logic [CAPW-1:0]     cap_ext, cap_eff, cnt_ext, rd_ext, n_lim, n_m1;
  logic [CAPW-1:0]     ins_c1, ins_c2;
  logic [CNT_W-1:0]    cnt_ins;
  logic [DEPTH-1:0]    match, hit_hi, hit_lo;
  logic                hit;
  logic                rd_done;

  logic                do_pop, do_ins, do_rem, do_clr, do_rot, do_emit, do_empty;
  logic [CNT_W-1:0]    cur_idx;

  // Effective capacity: zero counts as one, anything above the depth saturates.
  assign cap_ext = CAPW'(cap_q);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CAPW'(1);
    end else if (cap_ext > CAPW'(DEPTH)) begin
      cap_eff = CAPW'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign cnt_ext = CAPW'(cnt_q);
  assign rd_ext  = CAPW'(rd_idx_q);
  assign n_lim   = (cnt_ext > CAPW'(MAX_RESULTS)) ? CAPW'(MAX_RESULTS) : cnt_ext;
  assign n_m1    = n_lim - CAPW'(1);
  assign rd_done = (rd_ext == cnt_ext - CAPW'(1));

  // Per-cell compare of the head key against every held entry.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (ent_q[i] == head_key_i) && (i < int'(cnt_q));
    end
  end
  assign hit = |match;

  // Hit at or above a cell steers insert shifting; at or below steers remove.
  always_comb begin
    logic [DEPTH-1:0] lo_mask;
    for (int i = 0; i < DEPTH; i++) begin
      lo_mask   = {DEPTH{1'b1}} >> (DEPTH - 1 - i);
      hit_hi[i] = |(match >> i);
      hit_lo[i] = |(match & lo_mask);
    end
  end

  // Count after an insert: drop any duplicate, trim to one below capacity, add one.
  assign ins_c1  = cnt_ext - CAPW'(hit);
  assign ins_c2  = (ins_c1 > cap_eff - CAPW'(1)) ? (cap_eff - CAPW'(1)) : ins_c1;
  assign cnt_ins = CNT_W'(ins_c2 + CAPW'(1));

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid && (head_i.op == OP_READ) && (cnt_q > CNT_W'(1))) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    do_pop   = 1'b0;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_clr   = 1'b0;
    do_rot   = 1'b0;
    do_emit  = 1'b0;
    do_empty = 1'b0;
    cur_idx  = '0;
    case (state_q)
      ST_IDLE: begin
        do_pop = head_i.valid;
        if (head_i.valid) begin
          case (head_i.op)
            OP_INSERT: do_ins = 1'b1;
            OP_REMOVE: do_rem = 1'b1;
            OP_CLEAR:  do_clr = 1'b1;
            OP_READ: begin
              if (cnt_q == '0) begin
                do_empty = 1'b1;
              end else begin
                do_rot  = 1'b1;
                do_emit = 1'b1;
              end
            end
            default: do_clr = 1'b0;
          endcase
        end
      end
      ST_READ: begin
        cur_idx = rd_idx_q;
        do_rot  = 1'b1;
        do_emit = (rd_ext < CAPW'(MAX_RESULTS));
      end
      default: cur_idx = '0;
    endcase
  end

  assign rd_idx_d = (state_q == ST_IDLE) ? CNT_W'(1) : CNT_W'(rd_idx_q + CNT_W'(1));

  // Cell updates: insert shifts toward the back, remove closes the gap,
  // read out rotates the held entries so the front cell walks the list.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_d[i] = ent_q[i];
    end
    cnt_d = cnt_q;
    if (do_ins) begin
      ent_d[0] = head_key_i;
      for (int i = 1; i < DEPTH; i++) begin
        ent_d[i] = (!hit || hit_hi[i]) ? ent_q[i-1] : ent_q[i];
      end
      cnt_d = cnt_ins;
    end else if (do_rem) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ent_d[i] = hit_lo[i] ? ent_q[i+1] : ent_q[i];
      end
      cnt_d = cnt_q - CNT_W'(hit);
    end else if (do_clr) begin
      cnt_d = '0;
    end else if (do_rot) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ent_d[i] = (i == int'(cnt_q) - 1) ? ent_q[0] : ent_q[i+1];
      end
      ent_d[DEPTH-1] = ent_q[0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_BITS'(CAP_RESET);
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      res_valid_q <= do_emit || do_empty;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // List cells and result payload.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
    if (do_emit || do_empty) begin
      res_key_q   <= do_empty ? '0 : ent_q[0];
      res_pos_q   <= POS_BITS'(cur_idx);
      res_empty_q <= do_empty;
      res_last_q  <= do_empty || (CAPW'(cur_idx) == n_m1);
    end
  end

  assign pop_o       = do_pop;
  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_key_o   = res_key_q;
  assign res_pos_o   = res_pos_q;
  assign res_empty_o = res_empty_q;
  assign res_last_o  = res_last_q;

endmodule

>>> design/mru_key_list_top.sv
// Top level of the move-to-front MRU key list.
//
// Channel   Direction  Handshake                    Payload
// command   in         start, busy                  cmd_i, key_i
// result    out        result_valid_o (strobe)      entry_key_o, position_o, is_empty_o, last_o
// config    in         cfg_valid_i, cfg_ready_o     cfg_data_i (capacity)
//
// In the back end, insert and remove use a compare in every cell, and clear resets the count.
// A read out gives one result per held key (a single result for an empty list): the cell row
// rotates once per cycle, and at most 16 results come out, the first in the cycle after
// the back takes the item. A two-item queue sits between front and back.
// Reset empties the list and sets the capacity to 16; the cells need no clearing pass.
// busy is high while the queue is full; the result side cannot stall.
`include "assert_macros.svh"

module mru_key_list_top import mkl_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_BITS-1:0] cmd_i,
  input  logic [KEY_BITS-1:0] key_i,
  output logic                result_valid_o,
  output logic [KEY_BITS-1:0] entry_key_o,
  output logic [POS_BITS-1:0] position_o,
  output logic                is_empty_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CAP_BITS-1:0] cfg_data_i
);

  mkl_head_t           head;
  logic [KEY_BITS-1:0] head_key;
  logic                pop;
  logic                back_idle;

  // Front end: accept and classify.
  mkl_front #(
    .KEY_BITS(KEY_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (start),
    .cmd_i      (cmd_i),
    .key_i      (key_i),
    .pop_i      (pop),
    .full_o     (busy),
    .head_o     (head),
    .head_key_o (head_key)
  );

  // Back end: list cells and read-out sequencer.
  mkl_back #(
    .DEPTH   (DEPTH),
    .KEY_BITS(KEY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .head_key_i  (head_key),
    .pop_o       (pop),
    .idle_o      (back_idle),
    .res_valid_o (result_valid_o),
    .res_key_o   (entry_key_o),
    .res_pos_o   (position_o),
    .res_empty_o (is_empty_o),
    .res_last_o  (last_o)
  );

  // Capacity writes are taken once no item is queued or in progress.
  assign cfg_ready_o = back_idle && !head.valid;

  // An empty-list result is always the final one.
  `MKL_ASSERT(a_empty_is_last, result_valid_o && is_empty_o |-> last_o, "empty result not last")
  // A read out streams its results without gaps until the last one.
  `MKL_ASSERT(a_stream_gapless, result_valid_o && !last_o |=> result_valid_o, "gap in read out")
  // Configuration is only taken while the queue has room.
  `MKL_ASSERT(a_cfg_not_busy, cfg_ready_o |-> !busy, "config ready with full queue")
  // No result leaves while reset is held.
  `MKL_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !result_valid_o, "result during reset")

endmodule

>>> tb/mru_key_list_top_tb.sv
// Testbench for the MRU key list: directed and random command items checked against a predictor.
module mru_key_list_top_tb;
  import mkl_pkg::*;

  localparam int DEPTH         = 16;
  localparam int KEY_BITS      = 64;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 1000;
  localparam int POOL_SIZE     = 32;

  // One read-out entry as the block presents it.
  typedef struct packed {
    logic [KEY_BITS-1:0] entry_key;
    logic [POS_BITS-1:0] position;
    logic                is_empty;
    logic                last;
  } list_entry_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic [CMD_BITS-1:0] cmd_i       = CMD_INSERT;
  logic [KEY_BITS-1:0] key_i       = '0;
  logic                cfg_valid_i = 1'b0;
  logic [CAP_BITS-1:0] cfg_data_i  = '0;
  logic                busy;
  logic                result_valid_o;
  logic [KEY_BITS-1:0] entry_key_o;
  logic [POS_BITS-1:0] position_o;
  logic                is_empty_o;
  logic                last_o;
  logic                cfg_ready_o;

  // Predicted list contents and settings.
  logic [KEY_BITS-1:0] held_keys [DEPTH];
  int unsigned         held_count = 0;
  logic [CAP_BITS-1:0] list_capacity = CAP_RESET;
  list_entry_t         pending_entries [$];
  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
  int                  mismatch_count = 0;
  int                  idle_pct = 24;
  int                  stall_cycles = 0;

  mru_key_list_top #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .key_i          (key_i),
    .result_valid_o (result_valid_o),
    .entry_key_o    (entry_key_o),
    .position_o     (position_o),
    .is_empty_o     (is_empty_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Deletes the first held key equal to k and closes the gap.
  function automatic void drop_held_key(logic [KEY_BITS-1:0] k);
    for (int i = 0; i < held_count; i++) begin
      if (held_keys[i] == k) begin
        for (int j = i; j + 1 < held_count; j++) held_keys[j] = held_keys[j + 1];
        held_count--;
        return;
      end
    end
  endfunction

  // Applies one accepted item to the predicted list and queues its read-out entries.
  function automatic void update_list(logic [CMD_BITS-1:0] c, logic [KEY_BITS-1:0] k);
    int unsigned limit;
    list_entry_t e;
    if (list_capacity == 0) limit = 1;
    else if (list_capacity > DEPTH) limit = DEPTH;
    else limit = list_capacity;
    case (c)
      CMD_INSERT: begin
        drop_held_key(k);
        if (held_count > limit - 1) held_count = limit - 1;
        for (int i = held_count; i > 0; i--) held_keys[i] = held_keys[i - 1];
        held_keys[0] = k;
        held_count++;
      end
      CMD_REMOVE: drop_held_key(k);
      CMD_CLEAR: held_count = 0;
      default: begin
        if (held_count == 0) begin
          e = '{entry_key: '0, position: '0, is_empty: 1'b1, last: 1'b1};
          pending_entries.push_back(e);
        end else begin
          for (int i = 0; i < held_count; i++) begin
            e.entry_key = held_keys[i];
            e.position  = i[POS_BITS-1:0];
            e.is_empty  = 1'b0;
            e.last      = (i + 1 == held_count);
            pending_entries.push_back(e);
          end
        end
      end
    endcase
  endfunction

  // Sends one command item, at times after a random gap; start stays high on return.
  task automatic send_command(input logic [CMD_BITS-1:0] c, input logic [KEY_BITS-1:0] k);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(2, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    key_i <= k;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    update_list(c, k);
  endtask

  // Holds off the sender until every predicted entry has come out.
  task automatic wait_entries_drained();
    start <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
  endtask

  // Leaves the block idle: entries drained and queued items worked off.
  task automatic settle_block();
    wait_entries_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    list_capacity = value;
  endtask

  function automatic logic [CMD_BITS-1:0] pick_command(int insert_pct);
    int r;
    r = $urandom_range(99);
    if (r < insert_pct) return CMD_INSERT;
    if (r < insert_pct + (100 - insert_pct) * 2 / 5) return CMD_READ;
    if (r < 97) return CMD_REMOVE;
    return CMD_CLEAR;
  endfunction

  // Mostly keys from a small pool so that duplicates and hits are common.
  function automatic logic [KEY_BITS-1:0] pick_key(int span);
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(span - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic test_empty_list();
    send_command(CMD_READ, key_pool[2]);
    send_command(CMD_REMOVE, key_pool[2]);
    send_command(CMD_CLEAR, key_pool[3]);
    send_command(CMD_READ, '1);
  endtask

  task automatic test_insert_order();
    send_command(CMD_INSERT, '0);
    send_command(CMD_INSERT, '1);
    send_command(CMD_INSERT, 64'h5555_5555_5555_5555);
    send_command(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_command(CMD_READ, '0);
  endtask

  task automatic test_move_and_remove();
    // A held key moves to the front; a key not held is left alone.
    send_command(CMD_INSERT, '1);
    send_command(CMD_REMOVE, 64'h0123_4567_89AB_CDEF);
    send_command(CMD_REMOVE, '0);
    send_command(CMD_READ, '0);
    send_command(CMD_CLEAR, '0);
    send_command(CMD_READ, '0);
  endtask

  task automatic test_capacity_shrink();
    // The list keeps its entries past a lower capacity until the next insert.
    send_command(CMD_INSERT, key_pool[4]);
    send_command(CMD_INSERT, key_pool[5]);
    send_command(CMD_INSERT, key_pool[6]);
    write_capacity(5'd2);
    send_command(CMD_READ, '0);
    send_command(CMD_INSERT, key_pool[7]);
    send_command(CMD_READ, '0);
  endtask

  task automatic test_capacity_floor();
    // A capacity of zero behaves as one.
    write_capacity(5'd0);
    send_command(CMD_INSERT, key_pool[8]);
    send_command(CMD_INSERT, key_pool[9]);
    send_command(CMD_READ, '0);
  endtask

  task automatic test_random();
    logic [CAP_BITS-1:0] seg_cap [6];
    int                  seg_insert [6];
    int                  seg_span [6];
    logic [CMD_BITS-1:0] c;
    seg_cap    = '{5'd31, 5'd3, 5'd1, 5'd16, 5'd0, 5'd0};
    seg_insert = '{80, 55, 50, 60, 50, 60};
    seg_span   = '{32, 6, 3, 24, 4, 12};
    seg_cap[5] = $urandom_range(31);
    for (int seg = 0; seg < 6; seg++) begin
      write_capacity(seg_cap[seg]);
      idle_pct = (seg == 3) ? 0 : 24;
      for (int n = 0; n < 31; n++) begin
        c = pick_command(seg_insert[seg]);
        send_command(c, pick_key(seg_span[seg]));
        if (c == CMD_READ && ($urandom_range(19) == 0 || (seg == 1 && n >= 17 && n < 20)))
          wait_entries_drained();
      end
    end
  endtask

  // Main sequence.
  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_insert_order();
    test_move_and_remove();
    test_capacity_shrink();
    test_capacity_floor();
    test_random();
    settle_block();
    if (mismatch_count == 0) begin
      $display("mru_key_list_top verification clean");
    end else begin
      $display("mru_key_list_top verification failed");
    end
    $finish;
  end

  // Compares each read-out entry with the oldest predicted one.
  always @(posedge clk_i) begin : check_entries
    list_entry_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_entries.size() == 0) begin
        $error("entry with no prediction waiting: entry_key %h position %0d",
               entry_key_o, position_o);
        mismatch_count++;
      end else begin
        e = pending_entries.pop_front();
        if (entry_key_o !== e.entry_key) begin
          $error("entry_key mismatch: expected %h, actual %h", e.entry_key, entry_key_o);
          mismatch_count++;
        end
        if (position_o !== e.position) begin
          $error("position mismatch: expected %0d, actual %0d", e.position, position_o);
          mismatch_count++;
        end
        if (is_empty_o !== e.is_empty) begin
          $error("is_empty mismatch: expected %b, actual %b", e.is_empty, is_empty_o);
          mismatch_count++;
        end
        if (last_o !== e.last) begin
          $error("last mismatch: expected %b, actual %b", e.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("mru_key_list_top verification failed");
      $finish;
    end
  end

endmodule
